// ===== design/npis_pkg.sv =====
// npis_pkg: field widths, item kind codes and axis numbers of the nearest point search
// no dependencies; imported by every module of the block but npis_ram
`default_nettype none

package npis_pkg;

    localparam int KIND_W  = 1;
    localparam int ENTRY_W = 12;
    localparam int POS_W   = 24;
    localparam int OUT_W   = 12;
    localparam int CFG_W   = 13;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;
    localparam int AXES   = 3;

    localparam logic [CFG_W-1:0] COUNT_RESET = 13'd1;

endpackage

`default_nettype wire

// ===== design/nearest_point_index_search.sv =====
// nearest_point_index_search: table of 3d reference points and a linear nearest point search
// depends on npis_pkg, npis_ram, npis_cell
//
//   channel   signals                                          direction  handshake
//   command   start, busy, i_kind, i_entry_index, i_pos_x/y/z  in         start & !busy
//   result    o_result_valid, o_nearest_index                  out        one-cycle strobe
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data             in         valid & ready
//
// a load transaction writes one table entry in the cycle it is accepted; busy stays low
// a query runs its entries through the ram read and the x, y, z cells to the result strobe
//   (a zero count answers in the next cycle); one table entry per cycle sets the rate
// busy is high from query accept until the cycle of the result strobe; not for zero counts
// config is taken only while busy is low; the receiver cannot stall the result
// synchronous active-low reset clears control state and sets point_count to 1;
//   table contents are undefined until loaded
`default_nettype none

module nearest_point_index_search
    import npis_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // command transaction
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [KIND_W-1:0]       i_kind,
    input  wire logic [ENTRY_W-1:0]      i_entry_index,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    // result transaction
    output logic                         o_result_valid,
    output logic      [OUT_W-1:0]        o_nearest_index,
    // config transaction
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int C     = COORD_BITS;
    localparam int PT_W  = AXES * COORD_BITS;
    // three squares of values below 2^C
    localparam int SUM_W = 2 * COORD_BITS + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // control
    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_point_count;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic [IDX_W-1:0] r_last, n_last;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_nearest, n_nearest;

    // held query position and running best
    logic signed [C-1:0] r_qx, r_qy, r_qz;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    logic [SUM_W-1:0]    r_best_sum, n_best_sum;

    // command decode
    logic             accept;
    logic             is_load;
    logic             load_ok;
    logic             wr_en;
    logic             rd_en;
    logic [CNT_W-1:0] eff_count;
    logic signed [C-1:0] cx, cy, cz;
    logic [PT_W-1:0]  rd_pt;

    // chain taps
    logic             xy_valid, yz_valid, cmp_valid;
    logic [IDX_W-1:0] xy_idx, yz_idx, cmp_idx;
    logic [PT_W-1:0]  xy_pt, yz_pt, cmp_pt;
    logic [SUM_W-1:0] xy_sum, yz_sum, cmp_sum;
    logic             take;
    logic [IDX_W-1:0] sel_idx;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;
    assign is_load     = (i_kind == KIND_LOAD);

    // loads beyond the table are dropped
    assign load_ok = ({{(32-ENTRY_W){1'b0}}, i_entry_index} < 32'(MAX_POINTS));
    assign wr_en   = accept && is_load && load_ok;

    // only the low coord bits count, sign extended from the top one
    assign cx = C'(i_pos_x);
    assign cy = C'(i_pos_y);
    assign cz = C'(i_pos_z);

    // a count above the table size searches the whole table
    always_comb begin
        if ({{(32-CFG_W){1'b0}}, r_point_count} > 32'(MAX_POINTS)) begin
            eff_count = CNT_W'(MAX_POINTS);
        end else begin
            eff_count = CNT_W'(r_point_count);
        end
    end

    npis_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_entry_index)),
        .i_wr_data ({cz, cy, cx}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_pt)
    );

    // squared distance chain: x, then y, then z
    npis_cell #(
        .COORD_BITS (COORD_BITS), .IDX_W (IDX_W), .SUM_W (SUM_W), .AXIS (AXIS_X)
    ) u_cell_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_pt    (rd_pt),
        .i_sum   ({SUM_W{1'b0}}),
        .i_q     (r_qx),
        .o_valid (xy_valid),
        .o_idx   (xy_idx),
        .o_pt    (xy_pt),
        .o_sum   (xy_sum)
    );

    npis_cell #(
        .COORD_BITS (COORD_BITS), .IDX_W (IDX_W), .SUM_W (SUM_W), .AXIS (AXIS_Y)
    ) u_cell_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xy_valid),
        .i_idx   (xy_idx),
        .i_pt    (xy_pt),
        .i_sum   (xy_sum),
        .i_q     (r_qy),
        .o_valid (yz_valid),
        .o_idx   (yz_idx),
        .o_pt    (yz_pt),
        .o_sum   (yz_sum)
    );

    npis_cell #(
        .COORD_BITS (COORD_BITS), .IDX_W (IDX_W), .SUM_W (SUM_W), .AXIS (AXIS_Z)
    ) u_cell_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yz_valid),
        .i_idx   (yz_idx),
        .i_pt    (yz_pt),
        .i_sum   (yz_sum),
        .i_q     (r_qz),
        .o_valid (cmp_valid),
        .o_idx   (cmp_idx),
        .o_pt    (cmp_pt),
        .o_sum   (cmp_sum)
    );

    // first entry always taken; strict less-than keeps the lowest index on a tie.
    // the point itself is not needed past the chain, only the distance
    assign take    = cmp_valid && ((cmp_idx == '0) || (cmp_sum < r_best_sum));
    assign sel_idx = take ? cmp_idx : r_best_idx;

    always_comb begin
        n_state     = r_state;
        n_rd_addr   = r_rd_addr;
        n_last      = r_last;
        n_out_valid = 1'b0;
        n_nearest   = r_nearest;
        n_best_idx  = take ? cmp_idx : r_best_idx;
        n_best_sum  = take ? cmp_sum : r_best_sum;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !is_load) begin
                    if (r_point_count == '0) begin
                        // nothing to search
                        n_out_valid = 1'b1;
                        n_nearest   = '0;
                    end else begin
                        n_state   = ST_SCAN;
                        n_rd_addr = '0;
                        n_last    = IDX_W'(eff_count - CNT_W'(1));
                    end
                end
            end
            ST_SCAN: begin
                rd_en     = 1'b1;
                n_rd_addr = r_rd_addr + IDX_W'(1);
                if (r_rd_addr == r_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (cmp_valid && (cmp_idx == r_last)) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_nearest   = OUT_W'(sel_idx);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_point_count <= COUNT_RESET;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= rd_en;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_last     <= n_last;
        r_rd_idx   <= r_rd_addr;
        r_nearest  <= n_nearest;
        r_best_idx <= n_best_idx;
        r_best_sum <= n_best_sum;
        if (accept && !is_load) begin
            r_qx <= cx;
            r_qy <= cy;
            r_qz <= cz;
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_nearest_index = r_nearest;

endmodule

`default_nettype wire

// ===== design/npis_ram.sv =====
// npis_ram: generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module npis_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/npis_cell.sv =====
// npis_cell: one cell of the distance chain, adds the square of one axis difference
// depends on npis_pkg; three of these in a row form the squared distance
`default_nettype none

module npis_cell
    import npis_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 12,
    parameter int SUM_W      = 50,
    parameter int AXIS       = AXIS_X
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [IDX_W-1:0]             i_idx,
    input  wire logic [AXES*COORD_BITS-1:0]   i_pt,
    input  wire logic [SUM_W-1:0]             i_sum,
    input  wire logic signed [COORD_BITS-1:0] i_q,
    output logic                              o_valid,
    output logic      [IDX_W-1:0]             o_idx,
    output logic      [AXES*COORD_BITS-1:0]   o_pt,
    output logic      [SUM_W-1:0]             o_sum
);

    localparam int C  = COORD_BITS;
    localparam int PW = AXES * COORD_BITS;

    logic signed [C-1:0] coord;
    logic signed [C:0]   diff;
    logic        [C:0]   abs_diff;
    logic        [2*C-1:0] d_wide;

    // stage 1: absolute difference
    logic            r1_valid;
    logic [IDX_W-1:0] r1_idx;
    logic [PW-1:0]   r1_pt;
    logic [SUM_W-1:0] r1_sum;
    logic [C-1:0]    r1_d;
    // stage 2: square
    logic            r2_valid;
    logic [IDX_W-1:0] r2_idx;
    logic [PW-1:0]   r2_pt;
    logic [SUM_W-1:0] r2_sum;
    logic [2*C-1:0]  r2_sq;
    // stage 3: accumulate
    logic            r3_valid;
    logic [IDX_W-1:0] r3_idx;
    logic [PW-1:0]   r3_pt;
    logic [SUM_W-1:0] r3_sum;

    always_comb begin
        coord    = i_pt[AXIS*C +: C];
        diff     = {coord[C-1], coord} - {i_q[C-1], i_q};
        abs_diff = diff[C] ? (C+1)'(-diff) : diff;
        d_wide   = {{C{1'b0}}, r1_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx <= i_idx;
        r1_pt  <= i_pt;
        r1_sum <= i_sum;
        r1_d   <= abs_diff[C-1:0];

        r2_idx <= r1_idx;
        r2_pt  <= r1_pt;
        r2_sum <= r1_sum;
        r2_sq  <= d_wide * d_wide;

        r3_idx <= r2_idx;
        r3_pt  <= r2_pt;
        r3_sum <= r2_sum + SUM_W'(r2_sq);
    end

    assign o_valid = r3_valid;
    assign o_idx   = r3_idx;
    assign o_pt    = r3_pt;
    assign o_sum   = r3_sum;

endmodule

`default_nettype wire

// ===== design/npis_checker.sv =====
// npis_checker: port-level assertions on command, result and config behavior over time
// depends on npis_pkg; bound to nearest_point_index_search
`default_nettype none

module npis_checker
    import npis_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [KIND_W-1:0] i_kind,
    input wire logic              o_result_valid,
    input wire logic              o_cfg_ready
);

    // a query either goes busy or answers at once
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_QUERY)) |=> (busy || o_result_valid))
        else $error("query accepted but neither busy nor answered");

    // a load gives no result and leaves the block free
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_LOAD)) |=> (!o_result_valid && !busy))
        else $error("load transaction produced a result or busy");

    // the search ends with exactly its result
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("search finished without a result");

    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while still searching");

    a_cfg_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready)
        else $error("config accepted during a search");

endmodule

bind nearest_point_index_search npis_checker u_npis_checker (.*);

`default_nettype wire

// ===== dv/nearest_point_index_search_tb.sv =====
// nearest_point_index_search_tb: self-checking bench for the nearest point search block
// depends on npis_pkg and nearest_point_index_search; builds tables, sweeps point_count and
// checks every nearest_index against an exact squared-distance search kept in the bench
`timescale 1ns / 1ps

module nearest_point_index_search_tb;
    import npis_pkg::*;

    localparam int TABLE_DEPTH   = 4096;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;     // covers the load write and the zero-count answer
    localparam int STALL_LIMIT   = 30000;  // well above the length of a full-table query
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PERCENT  = 31;
    localparam int CALM_FIRST    = 25;     // command transactions in this span never idle
    localparam int CALM_LAST     = 90;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        STEP_COMMAND,
        STEP_SET_COUNT,
        STEP_DRAIN
    } step_kind_e;

    // one planned step of the sender: a command, a point_count write or a drain pause
    typedef struct packed {
        step_kind_e          step;
        logic [KIND_W-1:0]   kind;
        logic [ENTRY_W-1:0]  entry;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [POS_W-1:0]    z;
        logic [CFG_W-1:0]    count;
    } step_t;

    // ---------------------------------------------------------------- dut signals
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [KIND_W-1:0]         i_kind = KIND_LOAD;
    logic [ENTRY_W-1:0]        i_entry_index = '0;
    logic signed [POS_W-1:0]   i_pos_x = '0;
    logic signed [POS_W-1:0]   i_pos_y = '0;
    logic signed [POS_W-1:0]   i_pos_z = '0;
    logic                      o_result_valid;
    logic [OUT_W-1:0]          o_nearest_index;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    nearest_point_index_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .o_result_valid  (o_result_valid),
        .o_nearest_index (o_nearest_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // ---------------------------------------------------------------- stimulus plan
    step_t plan_q[$];
    bit    loaded[TABLE_DEPTH];    // entries written so far in the plan
    int    loaded_prefix = 0;      // entries 0..loaded_prefix-1 are all written

    // bench copy of the block: table, point_count and the answers still owed
    logic signed [POS_W-1:0] pt_x[TABLE_DEPTH];
    logic signed [POS_W-1:0] pt_y[TABLE_DEPTH];
    logic signed [POS_W-1:0] pt_z[TABLE_DEPTH];
    logic [CFG_W-1:0]        count_reg = COUNT_RESET;
    logic [OUT_W-1:0]        expected_index_q[$];

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int commands_done = 0;
    int stall_cycles  = 0;
    step_t now_item;

    task automatic plan_load(input int idx, input logic [POS_W-1:0] x, y, z);
        step_t s;
        s = '0;
        s.step  = STEP_COMMAND;
        s.kind  = KIND_LOAD;
        s.entry = idx[ENTRY_W-1:0];
        s.x = x;
        s.y = y;
        s.z = z;
        plan_q = {plan_q, s};
        loaded[idx] = 1'b1;
        while (loaded_prefix < TABLE_DEPTH && loaded[loaded_prefix])
            loaded_prefix++;
    endtask

    task automatic plan_query(input logic [POS_W-1:0] x, y, z);
        step_t s;
        s = '0;
        s.step  = STEP_COMMAND;
        s.kind  = KIND_QUERY;
        s.entry = ENTRY_W'($urandom);   // ignored by the block, random anyway
        s.x = x;
        s.y = y;
        s.z = z;
        plan_q = {plan_q, s};
    endtask

    task automatic plan_count(input int n);
        step_t s;
        s = '0;
        s.step  = STEP_SET_COUNT;
        s.count = n[CFG_W-1:0];
        plan_q = {plan_q, s};
    endtask

    task automatic plan_drain();
        step_t s;
        s = '0;
        s.step = STEP_DRAIN;
        plan_q = {plan_q, s};
    endtask

    // coordinates: full range, a tight cluster for ties, the extremes, or a mid range
    function automatic logic [POS_W-1:0] pick_coord();
        logic [POS_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = POS_W'($urandom);
            1: v = POS_W'($urandom_range(0, 16) - 8);
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = POS_MAX;
                    1:       v = POS_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = POS_W'($urandom_range(0, 4000) - 2000);
        endcase
        return v;
    endfunction

    // random mix of loads and queries; point_count changes every few items and never
    // reaches past the written prefix of the table
    task automatic plan_random(input int items, input int count_hi);
        int hi;
        int idx;
        for (int i = 0; i < items; i++) begin
            if (i % 14 == 0) begin
                hi = (count_hi == 0 || count_hi > loaded_prefix) ? loaded_prefix : count_hi;
                plan_count($urandom_range(1, hi));
            end
            if (i == items / 2 || $urandom_range(0, 39) == 0)
                plan_drain();
            if ($urandom_range(0, 99) < 35) begin
                if (loaded_prefix < TABLE_DEPTH && $urandom_range(0, 1) == 0)
                    idx = loaded_prefix;
                else
                    idx = $urandom_range(0, (loaded_prefix < TABLE_DEPTH) ? loaded_prefix
                                                                           : TABLE_DEPTH - 1);
                plan_load(idx, pick_coord(), pick_coord(), pick_coord());
            end else begin
                plan_query(pick_coord(), pick_coord(), pick_coord());
            end
        end
    endtask

    // exact search: squared distances fit easily in 64 bits, strict less keeps the lowest index
    function automatic logic [OUT_W-1:0] nearest_entry(input logic signed [POS_W-1:0] qx, qy, qz);
        int               span;
        longint           dx;
        longint           dy;
        longint           dz;
        longint           sq_dist;
        longint           best_dist;
        logic [OUT_W-1:0] best;
        span = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
        best = '0;
        best_dist = 0;
        for (int i = 0; i < span; i++) begin
            dx = longint'(pt_x[i]) - longint'(qx);
            dy = longint'(pt_y[i]) - longint'(qy);
            dz = longint'(pt_z[i]) - longint'(qz);
            sq_dist = dx * dx + dy * dy + dz * dz;
            if (i == 0 || sq_dist < best_dist) begin
                best = i[OUT_W-1:0];
                best_dist = sq_dist;
            end
        end
        return best;
    endfunction

    // ---------------------------------------------------------------- driver
    // command and config transactions; each strobe gets one nonblocking write per edge
    always @(posedge i_clk) begin : command_driver
        logic  drive_start;
        logic  drive_cfg;
        step_t nxt;
        drive_start = start;
        drive_cfg   = i_cfg_valid;
        if (!i_rst_n) begin
            drive_start  = 1'b0;
            drive_cfg    = 1'b0;
            quiet_cycles = 0;
        end else begin
            // command transaction taken at this edge: update the bench copy
            if (start && !busy) begin
                if (now_item.kind == KIND_QUERY) begin
                    expected_index_q = {expected_index_q,
                        nearest_entry(now_item.x, now_item.y, now_item.z)};
                end else begin
                    pt_x[now_item.entry] = now_item.x;
                    pt_y[now_item.entry] = now_item.y;
                    pt_z[now_item.entry] = now_item.z;
                end
                commands_done++;
                drive_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                count_reg = i_cfg_data;
                drive_cfg = 1'b0;
            end

            // block counts as idle once nothing is owed and nothing is on the ports
            if (expected_index_q.size() == 0 && !busy && !start && !i_cfg_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!drive_start && !drive_cfg && plan_q.size() != 0) begin
                nxt = plan_q[0];
                case (nxt.step)
                    STEP_COMMAND: begin
                        // random gaps, except for one long stretch of back-to-back traffic
                        if ((commands_done >= CALM_FIRST && commands_done < CALM_LAST) ||
                            $urandom_range(0, 99) >= IDLE_PERCENT) begin
                            void'(plan_q.pop_front());
                            now_item      = nxt;
                            drive_start   = 1'b1;
                            i_kind        <= nxt.kind;
                            i_entry_index <= nxt.entry;
                            i_pos_x       <= nxt.x;
                            i_pos_y       <= nxt.y;
                            i_pos_z       <= nxt.z;
                        end
                    end
                    STEP_SET_COUNT: begin
                        // register writes only into an idle block
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            void'(plan_q.pop_front());
                            drive_cfg  = 1'b1;
                            i_cfg_data <= nxt.count;
                        end
                    end
                    default: begin
                        // sender holds off until every owed answer is back
                        if (quiet_cycles >= SETTLE_CYCLES)
                            void'(plan_q.pop_front());
                    end
                endcase
            end
        end
        start       <= drive_start;
        i_cfg_valid <= drive_cfg;
    end

    // ---------------------------------------------------------------- monitor
    // every result strobe is matched against the oldest owed answer
    always @(posedge i_clk) begin : result_monitor
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_result_valid) begin
            if (expected_index_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: nearest_index %0d", o_nearest_index);
            end else begin
                want = expected_index_q.pop_front();
                if (o_nearest_index !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("nearest_index mismatch: expected %0d, got %0d",
                                 want, o_nearest_index);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    // counts cycles without any transaction on any channel
    always @(posedge i_clk) begin : stall_watchdog
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_result_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        // reset count is 1: entry 1 must be invisible to the first query
        plan_load(0, POS_MAX, POS_MAX, POS_MAX);
        plan_load(1, POS_MIN, POS_MIN, POS_MIN);
        plan_query(POS_MIN, POS_MIN, POS_MIN);
        plan_count(2);
        plan_query(POS_MIN, POS_MIN, POS_MIN);
        plan_query(POS_MAX, POS_MAX, POS_MAX);
        // two identical points: lowest index wins the tie
        plan_load(2, 0, 0, 0);
        plan_load(3, 0, 0, 0);
        plan_load(4, 1, -1, 0);
        plan_load(5, -1, 0, 0);
        plan_load(6, 0, 1, 0);
        plan_load(7, POS_MAX, POS_MIN, 0);
        plan_count(8);
        plan_query(0, 0, 0);
        plan_query(1, -1, 0);
        plan_query(0, 0, 1);                   // ties between entries 2 and 3
        plan_query(POS_MAX, POS_MIN, 0);
        plan_query(POS_MIN, POS_MAX, POS_MAX);
        plan_query(-1, -1, -1);
        plan_query(POS_MAX, POS_MAX, POS_MIN);
        // zero count answers entry 0 whatever the position
        plan_count(0);
        plan_query(POS_MIN, POS_MIN, POS_MIN);
        plan_query(5, 5, 5);
        plan_count(1);
        plan_query(POS_MIN, POS_MIN, POS_MIN);

        // small tables, growing as the loads extend the prefix
        plan_random(60, 0);
        plan_random(60, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() != 0 || start || i_cfg_valid || expected_index_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // any answer still owed here never came
        if (expected_index_q.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
